### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/i2cm_pkg.sv
// ---------------------------------------------------------------------------
// I2C master byte engine package
// Payload types, command and line action codes, phase sequence tables.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;
    localparam logic [15:0] PHASE_LENGTH_RST = 16'd8;

    // Command codes
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Line action codes
    localparam logic [2:0] ACT_SDA_REL = 3'd0;
    localparam logic [2:0] ACT_SDA_LOW = 3'd1;
    localparam logic [2:0] ACT_SCL_REL = 3'd2;
    localparam logic [2:0] ACT_SCL_LOW = 3'd3;
    localparam logic [2:0] ACT_SDA_BIT = 3'd4;
    localparam logic [2:0] ACT_SDA_ACK = 3'd5;

    localparam logic [4:0] START_PHASES = 5'd4;
    localparam logic [4:0] STOP_PHASES  = 5'd3;
    localparam logic [4:0] WRITE_PHASES = 5'd27;
    localparam logic [4:0] READ_PHASES  = 5'd20;
    localparam logic [4:0] WRITE_ACK_PHASE = 5'd25;
    localparam logic [4:0] READ_LAST_BIT_PHASE = 5'd16;

    localparam logic [2:0] START_SEQ [4] = '{
        ACT_SDA_REL, ACT_SCL_REL, ACT_SDA_LOW, ACT_SCL_LOW
    };
    localparam logic [2:0] STOP_SEQ [3] = '{
        ACT_SDA_LOW, ACT_SCL_REL, ACT_SDA_REL
    };
    localparam logic [2:0] WRITE_SEQ [27] = '{
        ACT_SDA_BIT, ACT_SCL_REL, ACT_SCL_LOW,
        ACT_SDA_BIT, ACT_SCL_REL, ACT_SCL_LOW,
        ACT_SDA_BIT, ACT_SCL_REL, ACT_SCL_LOW,
        ACT_SDA_BIT, ACT_SCL_REL, ACT_SCL_LOW,
        ACT_SDA_BIT, ACT_SCL_REL, ACT_SCL_LOW,
        ACT_SDA_BIT, ACT_SCL_REL, ACT_SCL_LOW,
        ACT_SDA_BIT, ACT_SCL_REL, ACT_SCL_LOW,
        ACT_SDA_BIT, ACT_SCL_REL, ACT_SCL_LOW,
        ACT_SDA_REL, ACT_SCL_REL, ACT_SCL_LOW
    };
    localparam logic [2:0] READ_SEQ [20] = '{
        ACT_SDA_REL,
        ACT_SCL_REL, ACT_SCL_LOW, ACT_SCL_REL, ACT_SCL_LOW,
        ACT_SCL_REL, ACT_SCL_LOW, ACT_SCL_REL, ACT_SCL_LOW,
        ACT_SCL_REL, ACT_SCL_LOW, ACT_SCL_REL, ACT_SCL_LOW,
        ACT_SCL_REL, ACT_SCL_LOW, ACT_SCL_REL, ACT_SCL_LOW,
        ACT_SDA_ACK, ACT_SCL_REL, ACT_SCL_LOW
    };

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] write_data;
        logic       read_ack;
        logic       sda_in;
    } cmd_item_t;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_seen;
    } rsp_item_t;

    // Classified tick: cmd is OP_NONE unless a valid command code arrived
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] write_data;
        logic       read_ack;
        logic       sda_in;
    } tick_t;

    typedef struct packed {
        logic [2:0] act;
        logic       sample;
    } phase_t;

    function automatic logic [4:0] phase_count(input logic [2:0] cmd);
        logic [4:0] n;
        case (cmd)
            OP_START: n = START_PHASES;
            OP_STOP:  n = STOP_PHASES;
            OP_WRITE: n = WRITE_PHASES;
            OP_READ:  n = READ_PHASES;
            default:  n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic phase_t phase_action(input logic [2:0] cmd, input logic [4:0] idx);
        phase_t p;
        p.act    = ACT_SDA_REL;
        p.sample = 1'b0;
        case (cmd)
            OP_START: p.act = START_SEQ[idx[1:0]];
            OP_STOP:
            begin
                if (idx < STOP_PHASES)
                begin
                    p.act = STOP_SEQ[idx[1:0]];
                end
            end
            OP_WRITE:
            begin
                if (idx < WRITE_PHASES)
                begin
                    p.act = WRITE_SEQ[idx];
                end
                p.sample = (idx == WRITE_ACK_PHASE);
            end
            OP_READ:
            begin
                p.act = (idx < READ_PHASES) ? READ_SEQ[idx] : ACT_SCL_LOW;
                p.sample = idx[0] && (idx <= READ_LAST_BIT_PHASE);
            end
            default: p.act = ACT_SDA_REL;
        endcase
        return p;
    endfunction

endpackage

### rtl/i2cm_front.sv
// ---------------------------------------------------------------------------
// I2C master front end
// Takes command items and classifies the operation code for the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cm_front import i2cm_pkg::*; (
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_item_t cmd,
    input  logic      q_ready,
    output logic      q_push,
    output tick_t     q_data
);

    logic known_op;

    assign cmd_ready = q_ready;
    assign q_push    = cmd_valid && q_ready;

    // Drop unknown codes to a plain tick
    assign known_op = (cmd.operation == OP_START) || (cmd.operation == OP_STOP) ||
                      (cmd.operation == OP_WRITE) || (cmd.operation == OP_READ);

    always_comb
    begin
        q_data.cmd        = known_op ? cmd.operation : OP_NONE;
        q_data.write_data = cmd.write_data;
        q_data.read_ack   = cmd.read_ack;
        q_data.sda_in     = cmd.sda_in;
    end

endmodule

### rtl/i2cm_queue.sv
// ---------------------------------------------------------------------------
// I2C master tick queue
// Small register FIFO between the front end and the bus engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cm_queue import i2cm_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  tick_t push_data,
    output logic  not_full,
    input  logic  pop,
    output logic  not_empty,
    output tick_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tick_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign not_full  = (count_reg != FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/i2cm_engine.sv
// ---------------------------------------------------------------------------
// I2C master bus engine
// Steps the phase sequencer once per tick and registers the line result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cm_engine import i2cm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] phase_length,
    input  logic        q_valid,
    input  tick_t       q_data,
    output logic        q_pop,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_item_t   rsp
);

    logic [15:0] tick_count_reg, tick_count_next;
    logic [4:0]  phase_index_reg, phase_index_next;
    logic [2:0]  active_reg, active_next;
    logic [7:0]  shift_reg, shift_next;
    logic        ack_mode_reg, ack_mode_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        ack_flag_reg, ack_flag_next;
    logic [7:0]  last_read_reg, last_read_next;
    logic        rsp_valid_reg;
    rsp_item_t   rsp_reg, rsp_next;

    logic [15:0] len;
    logic [15:0] tick_inc;
    logic        done;
    phase_t      ph;

    // Advance when the output slot is free or being emptied
    assign q_pop     = q_valid && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign len       = (phase_length == 16'd0) ? 16'd1 : phase_length;

    always_comb
    begin
        active_next      = active_reg;
        phase_index_next = phase_index_reg;
        tick_count_next  = tick_count_reg;
        shift_next       = shift_reg;
        ack_mode_next    = ack_mode_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        ack_flag_next    = ack_flag_reg;
        last_read_next   = last_read_reg;
        done             = 1'b0;
        tick_inc         = 16'd0;

        // Load a new command only when idle
        if (active_reg == OP_NONE && q_data.cmd != OP_NONE)
        begin
            active_next      = q_data.cmd;
            phase_index_next = 5'd0;
            tick_count_next  = 16'd0;
            shift_next       = (q_data.cmd == OP_WRITE) ? q_data.write_data : 8'd0;
            if (q_data.cmd == OP_READ)
            begin
                ack_mode_next = q_data.read_ack;
            end
        end

        ph = phase_action(active_next, phase_index_next);

        if (active_next != OP_NONE)
        begin
            if (tick_count_next == 16'd0)
            begin
                case (ph.act)
                    ACT_SDA_REL: sda_next = 1'b0;
                    ACT_SDA_LOW: sda_next = 1'b1;
                    ACT_SCL_REL: scl_next = 1'b0;
                    ACT_SCL_LOW: scl_next = 1'b1;
                    ACT_SDA_BIT:
                    begin
                        sda_next   = ~shift_next[7];
                        shift_next = {shift_next[6:0], 1'b0};
                    end
                    ACT_SDA_ACK: sda_next = ack_mode_next;
                    default:     sda_next = ack_mode_next;
                endcase
            end
            tick_inc = 16'(tick_count_next + 16'd1);
            if (tick_inc >= len)
            begin
                if (ph.sample)
                begin
                    if (active_next == OP_WRITE)
                    begin
                        ack_flag_next = ~q_data.sda_in;
                    end
                    else
                    begin
                        shift_next = {shift_next[6:0], q_data.sda_in};
                    end
                end
                tick_count_next  = 16'd0;
                phase_index_next = 5'(phase_index_next + 5'd1);
                if (phase_index_next >= phase_count(active_next))
                begin
                    if (active_next == OP_READ)
                    begin
                        last_read_next = shift_next;
                    end
                    active_next      = OP_NONE;
                    phase_index_next = 5'd0;
                    done             = 1'b1;
                end
            end
            else
            begin
                tick_count_next = tick_inc;
            end
        end

        rsp_next.scl_pull_low = scl_next;
        rsp_next.sda_pull_low = sda_next;
        rsp_next.busy_res     = (active_next != OP_NONE);
        rsp_next.done_res     = done;
        rsp_next.read_data    = last_read_next;
        rsp_next.ack_seen     = ack_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg  <= '0;
            phase_index_reg <= '0;
            active_reg      <= OP_NONE;
            shift_reg       <= '0;
            ack_mode_reg    <= 1'b0;
            scl_reg         <= 1'b0;
            sda_reg         <= 1'b0;
            ack_flag_reg    <= 1'b0;
            last_read_reg   <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                tick_count_reg  <= tick_count_next;
                phase_index_reg <= phase_index_next;
                active_reg      <= active_next;
                shift_reg       <= shift_next;
                ack_mode_reg    <= ack_mode_next;
                scl_reg         <= scl_next;
                sda_reg         <= sda_next;
                ack_flag_reg    <= ack_flag_next;
                last_read_reg   <= last_read_next;
                rsp_valid_reg   <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

### rtl/i2c_master_byte_engine_unit.sv
// ---------------------------------------------------------------------------
// I2C master byte engine
// Open-drain I2C master driven by one command item per bus tick.
// ---------------------------------------------------------------------------
//  channel  | signals                      | payload
//  ---------+------------------------------+-----------------------------
//  command  | cmd_valid / cmd_ready        | cmd (cmd_item_t)
//  result   | rsp_valid / rsp_ready        | rsp (rsp_item_t)
//  config   | cfg_valid / cfg_ready        | cfg_data (phase length)
//
//  One command item yields one result; one item is taken every cycle while the queue is not full.
//  Each item passes through the tick queue and then the result register.
//  The engine's tick update is combinational between queue head and result register.
//  Reset clears the engine to idle with both lines released, phase length 8.
//  A stalled result holds the engine; the queue keeps taking items until full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_byte_engine_unit import i2cm_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_item_t   cmd,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_item_t   rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [15:0] phase_length_reg;
    logic        q_ready, q_push, q_valid, q_pop;
    tick_t       q_in, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_length_reg <= PHASE_LENGTH_RST;
        end
        else if (cfg_valid)
        begin
            phase_length_reg <= cfg_data;
        end
    end

    i2cm_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .not_full  (q_ready),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    i2cm_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .phase_length (phase_length_reg),
        .q_valid      (q_valid),
        .q_data       (q_head),
        .q_pop        (q_pop),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp)
    );

endmodule

### rtl/i2cm_checker.sv
// ---------------------------------------------------------------------------
// I2C master port checker
// Watches the top-level ports for ordering and result consistency.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2cm_checker import i2cm_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_item_t rsp
);

    localparam int unsigned OUT_W = $clog2(QUEUE_DEPTH + 2);
    localparam logic [OUT_W-1:0] MAX_OUT = OUT_W'(QUEUE_DEPTH + 1);

    logic [OUT_W-1:0] outstanding_reg, outstanding_next;
    logic             cmd_xfer, rsp_xfer;

    assign cmd_xfer = cmd_valid && cmd_ready;
    assign rsp_xfer = rsp_valid && rsp_ready;

    // Track items taken but not yet answered
    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (cmd_xfer && !rsp_xfer)
        begin
            outstanding_next = OUT_W'(outstanding_reg + 1'b1);
        end
        else if (rsp_xfer && !cmd_xfer)
        begin
            outstanding_next = OUT_W'(outstanding_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    `ASSERT_IMP(a_no_orphan_rsp, clk, rst_n, rsp_valid, outstanding_reg != '0)
    `ASSERT_IMP(a_bounded_inflight, clk, rst_n, 1'b1, outstanding_reg <= MAX_OUT)
    `ASSERT_IMP(a_done_not_busy, clk, rst_n, rsp_valid && rsp.done_res, !rsp.busy_res)
    `ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind i2c_master_byte_engine_unit i2cm_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

### tb/testbench.sv
// ---------------------------------------------------------------------------
// I2C master byte engine testbench
// Feeds bus ticks with commands through the command channel and checks
// every result transfer against a cycle-by-tick model of the engine. A short
// table of directed ticks comes first. Random phases follow, each with its
// own phase length and its own idle and stall pattern. A final phase starts
// one command at the longest phase length and runs a few of its ticks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import i2cm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    // Command codes the engine ignores
    localparam logic [2:0] OP_RSVD_5 = 3'd5;
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    localparam rsp_item_t IDLE_RSP  = '0;
    localparam rsp_item_t START_RSP = '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};

    typedef struct packed {
        cmd_item_t item;
        logic      pinned;
        rsp_item_t want;
        logic      finish_cmd;
    } dir_row_t;

    localparam int DIR_ROWS = 20;
    // Rows below this one run at the phase length left by reset
    localparam int SLOW_ROWS = 6;
    localparam logic [15:0] DIR_FAST_LEN = 16'd2;
    localparam int SLOW_TICKS = 40;
    localparam int RAND_COUNT = 200;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{'{OP_NONE,   8'h00, 1'b0, 1'b0}, 1'b1, IDLE_RSP,  1'b0},
        '{'{OP_RSVD_5, 8'hFF, 1'b1, 1'b1}, 1'b1, IDLE_RSP,  1'b0},
        '{'{OP_RSVD_6, 8'h5A, 1'b0, 1'b1}, 1'b1, IDLE_RSP,  1'b0},
        '{'{OP_RSVD_7, 8'h00, 1'b1, 1'b0}, 1'b1, IDLE_RSP,  1'b0},
        '{'{OP_START,  8'hFF, 1'b1, 1'b1}, 1'b1, START_RSP, 1'b0},
        '{'{OP_WRITE,  8'hA5, 1'b0, 1'b1}, 1'b0, IDLE_RSP,  1'b1},
        '{'{OP_WRITE,  8'h00, 1'b0, 1'b0}, 1'b0, IDLE_RSP,  1'b1},
        '{'{OP_WRITE,  8'hFF, 1'b1, 1'b1}, 1'b0, IDLE_RSP,  1'b1},
        '{'{OP_READ,   8'h00, 1'b1, 1'b1}, 1'b0, IDLE_RSP,  1'b1},
        '{'{OP_READ,   8'hFF, 1'b0, 1'b0}, 1'b0, IDLE_RSP,  1'b1},
        '{'{OP_STOP,   8'h00, 1'b0, 1'b1}, 1'b0, IDLE_RSP,  1'b1},
        '{'{OP_STOP,   8'hFF, 1'b1, 1'b0}, 1'b0, IDLE_RSP,  1'b1},
        '{'{OP_START,  8'h00, 1'b0, 1'b0}, 1'b0, IDLE_RSP,  1'b0},
        '{'{OP_READ,   8'hFF, 1'b1, 1'b0}, 1'b0, IDLE_RSP,  1'b0},
        '{'{OP_STOP,   8'h00, 1'b0, 1'b1}, 1'b0, IDLE_RSP,  1'b1},
        '{'{OP_WRITE,  8'h80, 1'b0, 1'b0}, 1'b0, IDLE_RSP,  1'b1},
        '{'{OP_WRITE,  8'h01, 1'b1, 1'b1}, 1'b0, IDLE_RSP,  1'b1},
        '{'{OP_READ,   8'h7E, 1'b1, 1'b0}, 1'b0, IDLE_RSP,  1'b1},
        '{'{OP_READ,   8'h81, 1'b0, 1'b1}, 1'b0, IDLE_RSP,  1'b1},
        '{'{OP_STOP,   8'h00, 1'b0, 1'b0}, 1'b0, IDLE_RSP,  1'b1}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    cmd_item_t   cmd = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_item_t   rsp;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = PHASE_LENGTH_RST;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int quiet_cycles = 0;

    rsp_item_t bus_outputs_due [$];

    // Engine model state
    logic [15:0] eng_len;
    logic [15:0] eng_ticks;
    logic [4:0]  eng_phase;
    logic [2:0]  eng_op;
    logic [7:0]  eng_shift;
    logic        eng_ack_mode;
    logic        eng_scl;
    logic        eng_sda;
    logic        eng_ack;
    logic [7:0]  eng_last_read;

    i2c_master_byte_engine_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the engine model by one tick and return the line state after it.
    function automatic rsp_item_t engine_tick(input cmd_item_t it);
        rsp_item_t  r;
        logic [2:0] act;
        logic       smp;
        logic [4:0] nph;
        logic [15:0] len;
        logic       done;
        done = 1'b0;
        smp  = 1'b0;
        act  = ACT_SDA_REL;
        nph  = '0;
        len  = (eng_len == 16'd0) ? 16'd1 : eng_len;
        if (eng_op == OP_NONE && it.operation >= OP_START && it.operation <= OP_READ)
        begin
            eng_op    = it.operation;
            eng_phase = '0;
            eng_ticks = '0;
            eng_shift = (it.operation == OP_WRITE) ? it.write_data : 8'h00;
            if (it.operation == OP_READ)
            begin
                eng_ack_mode = it.read_ack;
            end
        end
        if (eng_op != OP_NONE)
        begin
            case (eng_op)
                OP_START:
                begin
                    nph = START_PHASES;
                    case (eng_phase[1:0])
                        2'd0:    act = ACT_SDA_REL;
                        2'd1:    act = ACT_SCL_REL;
                        2'd2:    act = ACT_SDA_LOW;
                        default: act = ACT_SCL_LOW;
                    endcase
                end
                OP_STOP:
                begin
                    nph = STOP_PHASES;
                    if (eng_phase == 5'd0)
                    begin
                        act = ACT_SDA_LOW;
                    end
                    else if (eng_phase == 5'd1)
                    begin
                        act = ACT_SCL_REL;
                    end
                    else
                    begin
                        act = ACT_SDA_REL;
                    end
                end
                OP_WRITE:
                begin
                    nph = WRITE_PHASES;
                    if (eng_phase < 5'd24)
                    begin
                        case (eng_phase % 3)
                            0:       act = ACT_SDA_BIT;
                            1:       act = ACT_SCL_REL;
                            default: act = ACT_SCL_LOW;
                        endcase
                    end
                    else if (eng_phase == WRITE_ACK_PHASE - 5'd1)
                    begin
                        act = ACT_SDA_REL;
                    end
                    else if (eng_phase == WRITE_ACK_PHASE)
                    begin
                        act = ACT_SCL_REL;
                        smp = 1'b1;
                    end
                    else
                    begin
                        act = ACT_SCL_LOW;
                    end
                end
                default:
                begin
                    nph = READ_PHASES;
                    if (eng_phase == 5'd0)
                    begin
                        act = ACT_SDA_REL;
                    end
                    else if (eng_phase <= READ_LAST_BIT_PHASE)
                    begin
                        act = eng_phase[0] ? ACT_SCL_REL : ACT_SCL_LOW;
                        smp = eng_phase[0];
                    end
                    else if (eng_phase == READ_LAST_BIT_PHASE + 5'd1)
                    begin
                        act = ACT_SDA_ACK;
                    end
                    else if (eng_phase == READ_LAST_BIT_PHASE + 5'd2)
                    begin
                        act = ACT_SCL_REL;
                    end
                    else
                    begin
                        act = ACT_SCL_LOW;
                    end
                end
            endcase
            // The line moves only on the first tick of a phase
            if (eng_ticks == 16'd0)
            begin
                case (act)
                    ACT_SDA_REL: eng_sda = 1'b0;
                    ACT_SDA_LOW: eng_sda = 1'b1;
                    ACT_SCL_REL: eng_scl = 1'b0;
                    ACT_SCL_LOW: eng_scl = 1'b1;
                    ACT_SDA_BIT:
                    begin
                        eng_sda   = ~eng_shift[7];
                        eng_shift = {eng_shift[6:0], 1'b0};
                    end
                    default:     eng_sda = eng_ack_mode;
                endcase
            end
            eng_ticks = eng_ticks + 16'd1;
            if (eng_ticks >= len)
            begin
                if (smp)
                begin
                    if (eng_op == OP_WRITE)
                    begin
                        eng_ack = ~it.sda_in;
                    end
                    else
                    begin
                        eng_shift = {eng_shift[6:0], it.sda_in};
                    end
                end
                eng_ticks = '0;
                eng_phase = eng_phase + 5'd1;
                if (eng_phase >= nph)
                begin
                    if (eng_op == OP_READ)
                    begin
                        eng_last_read = eng_shift;
                    end
                    eng_op    = OP_NONE;
                    eng_phase = '0;
                    done      = 1'b1;
                end
            end
        end
        r.scl_pull_low = eng_scl;
        r.sda_pull_low = eng_sda;
        r.busy_res     = (eng_op != OP_NONE);
        r.done_res     = done;
        r.read_data    = eng_last_read;
        r.ack_seen     = eng_ack;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        rsp_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (bus_outputs_due.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected: %0h", $time, rsp);
                error_count++;
            end
            else
            begin
                want = bus_outputs_due.pop_front();
                check_field("scl_pull_low", want.scl_pull_low, rsp.scl_pull_low);
                check_field("sda_pull_low", want.sda_pull_low, rsp.sda_pull_low);
                check_field("busy_res", want.busy_res, rsp.busy_res);
                check_field("done_res", want.done_res, rsp.done_res);
                check_field("read_data", want.read_data, rsp.read_data);
                check_field("ack_seen", want.ack_seen, rsp.ack_seen);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one tick; the expectation is the pinned value where one is given.
    task automatic send_item(input cmd_item_t it, input logic pinned, input rsp_item_t want);
        rsp_item_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= it;
        @(posedge clk);
        while (!cmd_ready)
        begin
            @(posedge clk);
        end
        predicted = engine_tick(it);
        bus_outputs_due.push_back(pinned ? want : predicted);
    endtask

    // Tick with no command until the running one finishes; negative level = random SDA.
    task automatic run_out(input int sda_level);
        cmd_item_t it;
        while (eng_op != OP_NONE)
        begin
            it.operation  = OP_NONE;
            it.write_data = 8'($urandom);
            it.read_ack   = 1'($urandom_range(1));
            it.sda_in     = (sda_level < 0) ? 1'($urandom_range(1)) : sda_level[0];
            send_item(it, 1'b0, IDLE_RSP);
        end
    endtask

    task automatic wait_drained();
        while (bus_outputs_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic settle();
        run_out(-1);
        cmd_valid <= 1'b0;
        wait_drained();
    endtask

    task automatic write_phase_len(input logic [15:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        eng_len = len;
    endtask

    task automatic random_phase(input logic [15:0] len, input int idle_pct,
                                input int stall_pct, input int count, input bit hold_mid);
        cmd_item_t it;
        int n;
        settle();
        write_phase_len(len);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (n = 0; n < count; n++)
        begin
            if (hold_mid && n == count / 2)
            begin
                // Hold the sender until the pipeline is empty
                cmd_valid <= 1'b0;
                wait_drained();
            end
            it.write_data = 8'($urandom);
            it.read_ack   = 1'($urandom_range(1));
            it.sda_in     = 1'($urandom_range(1));
            if (eng_op == OP_NONE)
            begin
                it.operation = ($urandom_range(99) < 85) ? 3'($urandom_range(OP_READ, OP_START))
                                                         : 3'($urandom_range(7));
            end
            else
            begin
                it.operation = ($urandom_range(99) < 90) ? OP_NONE : 3'($urandom_range(7));
            end
            send_item(it, 1'b0, IDLE_RSP);
        end
    endtask

    initial
    begin : stimulus
        cmd_item_t stop_item;
        int i;
        eng_len       = PHASE_LENGTH_RST;
        eng_ticks     = '0;
        eng_phase     = '0;
        eng_op        = OP_NONE;
        eng_shift     = '0;
        eng_ack_mode  = 1'b0;
        eng_scl       = 1'b0;
        eng_sda       = 1'b0;
        eng_ack       = 1'b0;
        eng_last_read = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            send_item(DIR_TABLE[i].item, DIR_TABLE[i].pinned, DIR_TABLE[i].want);
            if (DIR_TABLE[i].finish_cmd)
            begin
                run_out(int'(DIR_TABLE[i].item.sda_in));
            end
            if (i == SLOW_ROWS - 1)
            begin
                // Shorten the bus phases for the remaining rows
                settle();
                write_phase_len(DIR_FAST_LEN);
            end
        end

        random_phase(16'd1, 0, 0, RAND_COUNT, 1'b1);
        random_phase(16'd0, 87, 0, RAND_COUNT, 1'b0);
        random_phase(16'd2, 0, 87, RAND_COUNT, 1'b0);
        random_phase(16'd3, 32, 32, RAND_COUNT, 1'b0);

        // Start one stop at the slowest bus speed and run a few of its ticks
        settle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_phase_len(16'hFFFF);
        stop_item = '{OP_STOP, 8'h00, 1'b0, 1'b1};
        send_item(stop_item, 1'b0, IDLE_RSP);
        for (i = 0; i < SLOW_TICKS; i++)
        begin
            stop_item.operation = OP_NONE;
            stop_item.sda_in    = 1'($urandom_range(1));
            send_item(stop_item, 1'b0, IDLE_RSP);
        end
        cmd_valid <= 1'b0;
        wait_drained();

        repeat (4) @(posedge clk);
        if (error_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
